@@ rtl/core/are_pkg.sv @@
package are_pkg;

   localparam int CodeBits = 16;
   localparam int FreqBits = 14;
   localparam int IvBits = CodeBits + 1;
   localparam int ProdBits = FreqBits + IvBits;
   localparam int FollowBits = 32;
   localparam int TailBits = 5;
   localparam int QueueDepth = 2;

   localparam logic [IvBits-1:0] CodeOne = IvBits'(1) << CodeBits;
   localparam logic [IvBits-1:0] CodeHalf = IvBits'(1) << (CodeBits - 1);
   localparam logic [IvBits-1:0] CodeQuarter = IvBits'(1) << (CodeBits - 2);
   localparam logic [IvBits-1:0] CodeThreeQ = CodeHalf + CodeQuarter;
   localparam logic [TailBits-1:0] PadBits = TailBits'(16);

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FINISH = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // Command handed from the front part to the back part.
   typedef struct packed {
      op_type operation;
      logic [FreqBits-1:0] range_low;
      logic [FreqBits-1:0] range_high;
      logic [FreqBits-1:0] range_total;
   } cmd_type;

endpackage

@@ rtl/core/are_front.sv @@
module are_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_operation,
   input  logic [are_pkg::FreqBits-1:0] req_range_low,
   input  logic [are_pkg::FreqBits-1:0] req_range_high,
   input  logic [are_pkg::FreqBits-1:0] req_range_total,
   output logic cmd_valid,
   output are_pkg::cmd_type cmd_word,
   input  logic cmd_take
);
   import are_pkg::*;

   cmd_type queue_ff [QueueDepth];
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic keep, push, pop;
   cmd_type incoming;

   assign req_stall = (fill_ff == 2'(QueueDepth));

   always_comb begin
      incoming.operation = op_type'(req_operation);
      incoming.range_low = req_range_low;
      incoming.range_high = req_range_high;
      incoming.range_total = req_range_total;
      // Bad encode words and the unused code are dropped here.
      keep = 1'b1;
      unique case (incoming.operation)
         OP_ENCODE: keep = (req_range_total != '0) && (req_range_low < req_range_high)
                           && (req_range_high <= req_range_total);
         OP_UNUSED: keep = 1'b0;
         default: keep = 1'b1;
      endcase
   end

   assign push = req_valid && !req_stall && keep;
   assign pop = cmd_valid && cmd_take;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_word = queue_ff[rd_ptr_ff];
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign fill_in = fill_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

@@ rtl/core/are_div.sv @@
module are_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [are_pkg::ProdBits-1:0] dividend,
   input  logic [are_pkg::FreqBits-1:0] divisor,
   output logic done,
   output logic [are_pkg::ProdBits-1:0] quotient
);
   import are_pkg::*;

   localparam int CntBits = $clog2(ProdBits + 1);

   logic [ProdBits-1:0] quo_ff, quo_in;
   logic [FreqBits:0] rem_ff, rem_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [FreqBits:0] trial;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CntBits'(ProdBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[FreqBits-1:0], quo_ff[ProdBits-1]};
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[ProdBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[ProdBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CntBits'(1));
      end
   end

   assign done = busy_ff && (cnt_ff == CntBits'(1));
   assign quotient = quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

@@ rtl/core/are_back.sv @@
module are_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  are_pkg::cmd_type cmd_word,
   output logic cmd_take,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_lead_valid,
   output logic rsp_lead_bit,
   output logic [are_pkg::FollowBits-1:0] rsp_follow_count,
   output logic [are_pkg::TailBits-1:0] rsp_tail_zeros,
   output logic rsp_last
);
   import are_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_HI, ST_DIV_HI, ST_MUL_LO, ST_DIV_LO, ST_NORM
   } state_type;

   state_type state_ff;
   logic [IvBits-1:0] low_ff, high_ff, range_ff, new_high_ff;
   logic [FollowBits-1:0] pend_ff;
   cmd_type cmd_ff;
   logic [ProdBits-1:0] prod_ff;
   logic div_start_ff;
   logic div_done;
   logic [ProdBits-1:0] quotient;
   logic out_free;
   logic out_load;
   logic emit_now, middle_now;
   logic [FollowBits-1:0] pend_inc;

   logic held_ff, held_bit_ff;
   logic [FollowBits-1:0] held_follow_ff;

   logic rv_ff, rlv_ff, rbit_ff, rlast_ff;
   logic [FollowBits-1:0] rfollow_ff;
   logic [TailBits-1:0] rtail_ff;

   are_div u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend(prod_ff), .divisor(cmd_ff.range_total),
      .done(div_done), .quotient(quotient)
   );

   assign out_free = !rv_ff || !rsp_stall;
   assign cmd_take = (state_ff == ST_IDLE) && out_free;
   assign pend_inc = (pend_ff == '1) ? pend_ff : pend_ff + 1'b1;
   assign emit_now = (high_ff <= CodeHalf) || (low_ff >= CodeHalf);
   assign middle_now = (low_ff >= CodeQuarter) && (high_ff <= CodeThreeQ);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: out_load = cmd_valid && out_free && (cmd_word.operation == OP_FINISH);
         ST_NORM: out_load = held_ff && out_free && (emit_now || !middle_now);
         default: out_load = 1'b0;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_lead_valid = rlv_ff;
   assign rsp_lead_bit = rbit_ff;
   assign rsp_follow_count = rfollow_ff;
   assign rsp_tail_zeros = rtail_ff;
   assign rsp_last = rlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         low_ff <= '0;
         high_ff <= CodeOne;
         pend_ff <= '0;
         rv_ff <= 1'b0;
         held_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         rv_ff <= out_load || (rv_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && out_free) begin
                  cmd_ff <= cmd_word;
                  unique case (cmd_word.operation)
                     OP_START: begin
                        low_ff <= '0;
                        high_ff <= CodeOne;
                        pend_ff <= '0;
                     end
                     OP_ENCODE: begin
                        range_ff <= high_ff - low_ff;
                        state_ff <= ST_MUL_HI;
                     end
                     OP_FINISH: begin
                        rtail_ff <= PadBits;
                        rlast_ff <= 1'b1;
                        if (low_ff == '0 && high_ff == CodeOne && pend_ff == '0) begin
                           rlv_ff <= 1'b0;
                           rbit_ff <= 1'b0;
                           rfollow_ff <= '0;
                        end else if (low_ff == '0) begin
                           rlv_ff <= 1'b1;
                           rbit_ff <= 1'b0;
                           rfollow_ff <= pend_ff;
                        end else if (high_ff == CodeOne) begin
                           rlv_ff <= 1'b1;
                           rbit_ff <= 1'b1;
                           rfollow_ff <= pend_ff;
                        end else begin
                           rlv_ff <= 1'b1;
                           rbit_ff <= (low_ff >= CodeQuarter);
                           rfollow_ff <= pend_inc;
                        end
                        pend_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_MUL_HI: begin
               prod_ff <= ProdBits'(cmd_ff.range_high) * ProdBits'(range_ff);
               div_start_ff <= 1'b1;
               state_ff <= ST_DIV_HI;
            end
            ST_DIV_HI: begin
               if (div_done) begin
                  new_high_ff <= low_ff + IvBits'(quotient);
                  state_ff <= ST_MUL_LO;
               end
            end
            ST_MUL_LO: begin
               prod_ff <= ProdBits'(cmd_ff.range_low) * ProdBits'(range_ff);
               div_start_ff <= 1'b1;
               state_ff <= ST_DIV_LO;
            end
            ST_DIV_LO: begin
               if (div_done) begin
                  low_ff <= low_ff + IvBits'(quotient);
                  high_ff <= new_high_ff;
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               // One doubling step per cycle unless a held bit waits on a stalled response
               // register. An emitted bit is held back until the next emitted bit or the end
               // of renormalization shows whether it is the last word of this input.
               if (emit_now) begin
                  if (!held_ff || out_free) begin
                     if (held_ff) begin
                        rlv_ff <= 1'b1;
                        rbit_ff <= held_bit_ff;
                        rfollow_ff <= held_follow_ff;
                        rtail_ff <= '0;
                        rlast_ff <= 1'b0;
                     end
                     held_ff <= 1'b1;
                     held_bit_ff <= (high_ff > CodeHalf);
                     held_follow_ff <= pend_ff;
                     pend_ff <= '0;
                     if (high_ff <= CodeHalf) begin
                        low_ff <= low_ff << 1;
                        high_ff <= high_ff << 1;
                     end else begin
                        low_ff <= (low_ff - CodeHalf) << 1;
                        high_ff <= (high_ff - CodeHalf) << 1;
                     end
                  end
               end else if (middle_now) begin
                  pend_ff <= pend_inc;
                  low_ff <= (low_ff - CodeQuarter) << 1;
                  high_ff <= (high_ff - CodeQuarter) << 1;
               end else if (!held_ff || out_free) begin
                  if (held_ff) begin
                     rlv_ff <= 1'b1;
                     rbit_ff <= held_bit_ff;
                     rfollow_ff <= held_follow_ff;
                     rtail_ff <= '0;
                     rlast_ff <= 1'b1;
                  end
                  held_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/arithmetic_range_encoder.sv @@
// Binary arithmetic encoder with a 16-bit code interval. Each word carries an
// operation: start clears the interval, encode narrows it by a cumulative
// frequency range and renormalizes, finish emits the closing bit, when one is
// needed, and 16 zero pad bits. Every emitted bit is one response word with
// its pending follow count; rsp_last marks the final word of an input. A
// two-entry queue sits between the input side and the encoder. An encode word
// makes two passes of the shared bit-serial divider, each a load and then a
// 31-bit quotient, before renormalization, and an emitted bit waits while the
// response register is stalled. Start and finish are taken only once the
// response register is free.
module arithmetic_range_encoder (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_operation,
   input  logic [13:0] req_range_low,
   input  logic [13:0] req_range_high,
   input  logic [13:0] req_range_total,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_lead_valid,
   output logic rsp_lead_bit,
   output logic [31:0] rsp_follow_count,
   output logic [4:0] rsp_tail_zeros,
   output logic rsp_last
);
   import are_pkg::*;

   logic cmd_valid, cmd_take;
   cmd_type cmd_word;

   are_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_range_low(req_range_low),
      .req_range_high(req_range_high), .req_range_total(req_range_total),
      .cmd_valid(cmd_valid), .cmd_word(cmd_word), .cmd_take(cmd_take)
   );

   are_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_word(cmd_word),
      .cmd_take(cmd_take), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_lead_valid(rsp_lead_valid), .rsp_lead_bit(rsp_lead_bit),
      .rsp_follow_count(rsp_follow_count), .rsp_tail_zeros(rsp_tail_zeros),
      .rsp_last(rsp_last)
   );

   a_pad_only_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tail_zeros != '0 |-> rsp_last && rsp_tail_zeros == PadBits)
      else $error("pad bits on a non-final word");
   a_no_lead_no_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lead_valid |-> rsp_follow_count == '0 && rsp_tail_zeros == PadBits)
      else $error("empty word outside finish");
   a_take_needs_word: assert property (@(posedge clock) disable iff (reset)
      cmd_take && cmd_valid |=> !(rsp_valid && rsp_lead_valid && !rsp_last
         && rsp_tail_zeros != '0))
      else $error("bad word after command");

endmodule
